// ===== src/stereo_band_compressor_defines.svh =====
// assertion macros used by the checker file
`ifndef STEREO_BAND_COMPRESSOR_DEFINES_SVH
`define STEREO_BAND_COMPRESSOR_DEFINES_SVH

// check that is switched off while reset is high
`define SBC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also covers the reset cycles
`define SBC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// types, constants and helpers shared by the stereo band compressor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbc_pkg;

   localparam int FRONT_DEPTH = 2;

   localparam logic [19:0] ONE_Q16   = 20'd65536;
   localparam logic [15:0] DIV5_MULT = 16'd52429;

   // register indexes on the csr port
   localparam logic [2:0] CSR_THRESHOLD     = 3'd0;
   localparam logic [2:0] CSR_INVERSE_RATIO = 3'd1;
   localparam logic [2:0] CSR_RISE_COEF     = 3'd2;
   localparam logic [2:0] CSR_FALL_COEF     = 3'd3;
   localparam logic [2:0] CSR_OUTPUT_GAIN   = 3'd4;
   localparam logic [2:0] CSR_GATE_LEVEL    = 3'd5;
   localparam logic [2:0] CSR_BOOST_MAX     = 3'd6;

   typedef struct packed {
      logic signed [23:0] left_sample;
      logic signed [23:0] right_sample;
   } req_type;

   typedef struct packed {
      logic signed [23:0] left_out;
      logic signed [23:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [22:0] threshold;
      logic [16:0] inverse_ratio;
      logic [23:0] rise_coef;
      logic [23:0] fall_coef;
      logic [23:0] output_gain;
      logic [22:0] gate_level;
      logic [14:0] boost_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      threshold:     23'd838861,
      inverse_ratio: 17'd65536,
      rise_coef:     24'd16609444,
      fall_coef:     24'd16760438,
      output_gain:   24'd65536,
      gate_level:    23'd41943,
      boost_max:     15'd8192
   };

   // one channel after classification: sign and magnitude
   typedef struct packed {
      logic        neg;
      logic [23:0] mag;
   } chan_type;

   typedef struct packed {
      chan_type left;
      chan_type right;
   } item_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ENV1, S_ENV2, S_CLASS, S_LOG, S_EXPO,
      S_EXPSET, S_EXP, S_SCALE, S_GAIN, S_OUT
   } eng_state_type;

   // 2^(2^-(k+1)) for entry k, in q1.30
   localparam logic [30:0] EXP_TAB [16] = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
      31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
      31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
      31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
   };

   function automatic logic [4:0] lead_one(input logic [23:0] x);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 24; i++) begin
         if (x[i]) p = 5'(i);
      end
      return p;
   endfunction

   function automatic chan_type classify(input logic [23:0] raw);
      chan_type c;
      c.neg = raw[23];
      c.mag = raw[23] ? (24'd0 - raw) : {1'b0, raw[22:0]};
      return c;
   endfunction

endpackage

// ===== src/sbc_front.sv =====
// ----------------------------------------------------------------------------
// sbc_front
// takes requests, splits each sample into sign and magnitude, queues them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_front #(
   parameter int Depth = sbc_pkg::FRONT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  sbc_pkg::req_type  req_data,
   output logic              item_valid,
   input  logic              item_take,
   output sbc_pkg::item_type item
);
   import sbc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            queue_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;
   item_type            new_item;

   assign full       = (count_ff == CntW'(Depth));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      new_item.left  = classify(req_data.left_sample);
      new_item.right = classify(req_data.right_sample);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) queue_ff[wr_ptr_ff] <= new_item;
   end

endmodule

// ===== src/sbc_engine.sv =====
// ----------------------------------------------------------------------------
// sbc_engine
// envelope, gain and scaling for both channels on one shared multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_engine (
   input  logic              clock,
   input  logic              reset,
   input  sbc_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  sbc_pkg::item_type item,
   output logic              item_take,
   output logic              empty,
   input  logic              pop,
   output sbc_pkg::rsp_type  rsp_data
);
   import sbc_pkg::*;

   localparam logic signed [23:0] Y_MIN = -24'sd2097152;
   localparam logic signed [23:0] Y_MAX = 24'sd2031616;

   eng_state_type      state_ff, state_in;
   logic               ch_ff, ch_in;
   item_type           item_ff, item_in;
   logic [1:0][23:0]   env_ff, env_in;
   logic [47:0]        acc_ff, acc_in;
   logic               up_ff, up_in;
   logic [16:0]        emag_ff, emag_in;
   logic [4:0]         p_ff, p_in;
   logic [30:0]        m_ff, m_in;
   logic [15:0]        frac_ff, frac_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               lsel_ff, lsel_in;
   logic [20:0]        lenv_ff, lenv_in;
   logic [20:0]        lthr_ff, lthr_in;
   logic signed [23:0] y_ff, y_in;
   logic signed [5:0]  ip_ff, ip_in;
   logic [15:0]        f_ff, f_in;
   logic [19:0]        g_ff, g_in;
   logic [27:0]        t_ff, t_in;
   logic [23:0]        lres_ff, lres_in;
   rsp_type            rsp_ff, rsp_in;
   logic               ovalid_ff, ovalid_in;

   logic [31:0]        op_a, op_b;
   logic [63:0]        prod;
   chan_type           cur;
   logic [23:0]        env_cur, coef, env_new;
   logic [48:0]        env_sum;
   logic [29:0]        env20, thr21, thr19;
   logic [16:0]        irs;
   logic [22:0]        tl;
   logic [4:0]         lead_env, lead_thr;
   logic [31:0]        mm;
   logic [15:0]        frac_next;
   logic signed [21:0] l_val;
   logic [20:0]        l_mag;
   logic [39:0]        y_sum;
   logic signed [23:0] y_mag, yc;
   logic [62:0]        ex_sum;
   logic [5:0]         sh, lsh;
   logic [47:0]        g_wide;
   logic [18:0]        cap;
   logic [44:0]        t_sum;
   logic [52:0]        r_sum;
   logic [36:0]        r_val;
   logic [23:0]        out_val;
   logic               slot_free, gate, above, below;

   assign empty    = !ovalid_ff;
   assign rsp_data = rsp_ff;

   // shared operand selection
   always_comb begin
      cur       = ch_ff ? item_ff.right : item_ff.left;
      env_cur   = env_ff[ch_ff];
      coef      = (cur.mag > env_cur) ? cfg.rise_coef : cfg.fall_coef;
      irs       = (cfg.inverse_ratio > 17'd65536) ? 17'd65536 : cfg.inverse_ratio;
      tl        = (cfg.threshold == '0) ? 23'd1 : cfg.threshold;
      l_val     = up_ff ? ($signed({1'b0, lthr_ff}) - $signed({1'b0, lenv_ff}))
                        : ($signed({1'b0, lenv_ff}) - $signed({1'b0, lthr_ff}));
      l_mag     = l_val[21] ? 21'(-l_val) : l_val[20:0];
      op_a      = '0;
      op_b      = '0;
      case (state_ff)
         S_ENV1: begin
            op_a = 32'(cur.mag);
            op_b = 32'(25'h1000000 - {1'b0, coef});
         end
         S_ENV2: begin
            op_a = 32'(env_cur);
            op_b = 32'(coef);
         end
         S_CLASS: begin
            op_a = 32'(17'd65538 - irs);
            op_b = 32'(DIV5_MULT);
         end
         S_LOG: begin
            op_a = 32'(m_ff);
            op_b = 32'(m_ff);
         end
         S_EXPO: begin
            op_a = 32'(l_mag);
            op_b = 32'(emag_ff);
         end
         S_EXP: begin
            op_a = 32'(m_ff);
            op_b = 32'(EXP_TAB[cnt_ff]);
         end
         S_GAIN: begin
            op_a = 32'(g_ff);
            op_b = 32'(cfg.output_gain);
         end
         S_OUT: begin
            op_a = 32'(cur.mag);
            op_b = 32'(t_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod = op_a * op_b;
   end

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      item_in   = item_ff;
      env_in    = env_ff;
      acc_in    = acc_ff;
      up_in     = up_ff;
      emag_in   = emag_ff;
      p_in      = p_ff;
      m_in      = m_ff;
      frac_in   = frac_ff;
      cnt_in    = cnt_ff;
      lsel_in   = lsel_ff;
      lenv_in   = lenv_ff;
      lthr_in   = lthr_ff;
      y_in      = y_ff;
      ip_in     = ip_ff;
      f_in      = f_ff;
      g_in      = g_ff;
      t_in      = t_ff;
      lres_in   = lres_ff;
      rsp_in    = rsp_ff;
      item_take = 1'b0;
      slot_free = !ovalid_ff || pop;
      ovalid_in = ovalid_ff && !pop;

      env_sum   = {1'b0, acc_ff} + prod[48:0] + 49'h800000;
      env_new   = env_sum[47:24];
      env20     = 30'(env_cur) * 30'd20;
      thr21     = 30'(cfg.threshold) * 30'd21;
      thr19     = 30'(cfg.threshold) * 30'd19;
      gate      = env_cur <= {1'b0, cfg.gate_level};
      above     = env20 > thr21;
      below     = env20 < thr19;
      lead_env  = lead_one(env_cur);
      lead_thr  = lead_one({1'b0, tl});
      mm        = prod[61:30];
      frac_next = {frac_ff[14:0], mm[31]};
      y_sum     = {1'b0, prod[38:0]} + 40'd32768;
      y_mag     = $signed({1'b0, y_sum[38:16]});
      yc        = (y_ff < Y_MIN) ? Y_MIN : ((y_ff > Y_MAX) ? Y_MAX : y_ff);
      ex_sum    = {1'b0, prod[61:0]} + 63'h20000000;
      lsh       = $unsigned(ip_ff) - 6'd14;
      sh        = 6'd14 - $unsigned(ip_ff);
      if (ip_ff >= 6'sd14) begin
         g_wide = {17'b0, m_ff} << lsh;
      end else begin
         g_wide = ({17'b0, m_ff} + (48'd1 << (sh - 6'd1))) >> sh;
      end
      cap       = {cfg.boost_max, 4'b0};
      t_sum     = {1'b0, prod[43:0]} + 45'd32768;
      r_sum     = prod[52:0] + 53'd32768;
      r_val     = r_sum[52:16];
      if (cur.neg) begin
         out_val = (r_val > 37'd8388608) ? 24'h800000 : (24'd0 - r_val[23:0]);
      end else begin
         out_val = (r_val > 37'd8388607) ? 24'h7FFFFF : r_val[23:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               item_in   = item;
               ch_in     = 1'b0;
               state_in  = S_ENV1;
            end
         end
         S_ENV1: begin
            acc_in   = prod[47:0];
            state_in = S_ENV2;
         end
         S_ENV2: begin
            env_in[ch_ff] = env_new;
            state_in      = S_CLASS;
         end
         S_CLASS: begin
            if (gate || !(above || below)) begin
               g_in     = ONE_Q16;
               state_in = S_GAIN;
            end else begin
               up_in    = below;
               emag_in  = below ? prod[34:18] : (17'h10000 - irs);
               p_in     = lead_env;
               m_in     = {7'b0, env_cur} << (5'd30 - lead_env);
               frac_in  = '0;
               cnt_in   = '0;
               lsel_in  = 1'b0;
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            cnt_in  = cnt_ff + 4'd1;
            m_in    = mm[31] ? mm[31:1] : mm[30:0];
            frac_in = frac_next;
            if (cnt_ff == 4'd15) begin
               if (!lsel_ff) begin
                  // envelope done, start on the threshold
                  lenv_in = {p_ff, frac_next};
                  lsel_in = 1'b1;
                  p_in    = lead_thr;
                  m_in    = {8'b0, tl} << (5'd30 - lead_thr);
                  frac_in = '0;
               end else begin
                  lthr_in  = {p_ff, frac_next};
                  state_in = S_EXPO;
               end
            end
         end
         S_EXPO: begin
            // rounded half away from zero; downward exponent is negative
            y_in     = (l_val[21] ^ !up_ff) ? -y_mag : y_mag;
            state_in = S_EXPSET;
         end
         S_EXPSET: begin
            ip_in    = yc[21:16];
            f_in     = yc[15:0];
            m_in     = 31'h40000000;
            cnt_in   = '0;
            state_in = S_EXP;
         end
         S_EXP: begin
            if (f_ff[4'd15 - cnt_ff]) m_in = ex_sum[60:30];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = S_SCALE;
         end
         S_SCALE: begin
            if (up_ff && (g_wide > 48'(cap))) begin
               g_in = 20'(cap);
            end else begin
               g_in = g_wide[19:0];
            end
            state_in = S_GAIN;
         end
         S_GAIN: begin
            t_in     = t_sum[43:16];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!ch_ff) begin
               lres_in  = out_val;
               ch_in    = 1'b1;
               state_in = S_ENV1;
            end else if (slot_free) begin
               rsp_in.left_out  = lres_ff;
               rsp_in.right_out = out_val;
               ovalid_in        = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
         env_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         env_ff    <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      item_ff <= item_in;
      acc_ff  <= acc_in;
      up_ff   <= up_in;
      emag_ff <= emag_in;
      p_ff    <= p_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      lsel_ff <= lsel_in;
      lenv_ff <= lenv_in;
      lthr_ff <= lthr_in;
      y_ff    <= y_in;
      ip_ff   <= ip_in;
      f_ff    <= f_in;
      g_ff    <= g_in;
      t_ff    <= t_in;
      lres_ff <= lres_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== src/stereo_band_compressor.sv =====
// Stereo band compressor: one request carries a left/right sample pair and gives
// one processed pair. The engine takes a new request only once the last pair is
// done. A channel that sits at unity gain (gated or inside the threshold window)
// skips the gain computation; any other channel uses the single shared 32x32
// multiplier to run two 16-step log2 loops and one 16-step exp2 loop. A small
// request queue in front and a result register behind let both sides keep
// moving. The user must write configuration through the csr port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// stereo_band_compressor
// top level: csr registers, request queue and gain engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_band_compressor #(
   parameter int FrontDepth = sbc_pkg::FRONT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             push,
   output logic             full,
   input  sbc_pkg::req_type req_data,
   // result side
   output logic             empty,
   input  logic             pop,
   output sbc_pkg::rsp_type rsp_data,
   // csr write port
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_wdata
);
   import sbc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type item;
   logic     item_valid, item_take;

   // csr writes are always taken
   assign csr_ready = 1'b1;

   // register decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:     cfg_in.threshold     = csr_wdata[22:0];
            CSR_INVERSE_RATIO: cfg_in.inverse_ratio = csr_wdata[16:0];
            CSR_RISE_COEF:     cfg_in.rise_coef     = csr_wdata;
            CSR_FALL_COEF:     cfg_in.fall_coef     = csr_wdata;
            CSR_OUTPUT_GAIN:   cfg_in.output_gain   = csr_wdata;
            CSR_GATE_LEVEL:    cfg_in.gate_level    = csr_wdata[22:0];
            CSR_BOOST_MAX:     cfg_in.boost_max     = csr_wdata[14:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: sign/magnitude split and request queue
   sbc_front #(
      .Depth (FrontDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   // back: envelope, gain curve, output scaling, result register
   sbc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== src/sbc_checker.sv =====
// ----------------------------------------------------------------------------
// sbc_checker
// port level checks on the stereo band compressor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_band_compressor_defines.svh"

module sbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             push,
   input logic             full,
   input sbc_pkg::req_type req_data,
   input logic             empty,
   input logic             pop,
   input sbc_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [2:0]       csr_index,
   input logic [23:0]      csr_wdata
);

   // no result survives reset
   `SBC_ASSERT_RST(a_empty_after_reset, reset |=> empty, "result shown after reset")

   // request queue is drained by reset
   `SBC_ASSERT_RST(a_not_full_after_reset, reset |=> !full, "queue full after reset")

   // a waiting result holds until taken
   `SBC_ASSERT(a_rsp_hold, (!empty && !pop) |=> (!empty && $stable(rsp_data)), "result changed")

   // csr writes are never stalled
   `SBC_ASSERT(a_csr_ready, csr_valid |-> csr_ready, "csr write stalled")

endmodule

bind stereo_band_compressor sbc_checker u_sbc_checker (.*);
